/* rtl/b64d_pkg.sv */
// Shared types and character constants for the streaming Base64 decoder.
// No dependencies; used by the top level, b64d_core and b64d_outq.
package b64d_pkg;

	// Character codes
	localparam logic [7:0] CHAR_PAD        = 8'h3D; // '='
	localparam logic [7:0] CHAR_PLUS       = 8'h2B; // '+'
	localparam logic [7:0] CHAR_SLASH      = 8'h2F; // '/'
	localparam logic [7:0] CHAR_MINUS      = 8'h2D; // '-'
	localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F; // '_'
	localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;
	localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z    = 8'h7A;
	localparam logic [7:0] CHAR_DIGIT_0    = 8'h30;
	localparam logic [7:0] CHAR_DIGIT_9    = 8'h39;

	localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
	localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
	localparam logic [5:0] SEXTET_62         = 6'd62;
	localparam logic [5:0] SEXTET_63         = 6'd63;

	// Configuration register indexes (byte address 4*index)
	localparam int unsigned REG_URL_ALPHABET = 0;
	localparam int unsigned REG_STRICT_PAD   = 1;
	localparam int unsigned ADDR_W           = 3;

	localparam logic RESET_URL_ALPHABET = 1'b0;
	localparam logic RESET_STRICT_PAD   = 1'b1;

	localparam int unsigned MAX_RESULTS = 3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       rejected;
		logic       closing;
	} result_t;

	// Results of one item; res[0] goes out first
	typedef struct packed {
		logic [1:0]                   count;
		result_t [MAX_RESULTS-1:0]    res;
	} batch_t;

endpackage

/* rtl/base64_decoder_checked.sv */
// Top level of the streaming Base64 decoder with validity checking.
// Depends on b64d_pkg, b64d_core and b64d_outq.
//
//  channel  | direction | payload
//  s_*      | in        | tdata text_char, tlast message_end
//  m_*      | out       | tdata data_byte, tuser {rejected, byte_valid}, tlast closing
//  APB      | in/out    | 0x0 url_alphabet, 0x4 strict_pad
//
// One character is taken per cycle while the input register is not held; its results pass
// from the input register into the result buffer and leave one result per cycle while m_tready is high.
// A character that yields results waits in the input register until the
// buffer holds at most one result that is being taken.
// Reset clears group state, the buffer and sets the registers to defaults.
module base64_decoder_checked (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // text_char
	input  logic                          s_tlast,   // message_end
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,   // data_byte
	output logic [1:0]                    m_tuser,   // [0] byte_valid, [1] rejected
	output logic                          m_tlast,   // closing
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [b64d_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	logic             url_q;
	logic             strict_q;
	logic             wr_en;
	logic             reg_idx;
	logic             load_ok;
	logic             batch_load;
	b64d_pkg::batch_t batch;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[2];
	assign prdata  = {31'd0, (reg_idx == b64d_pkg::REG_STRICT_PAD[0]) ? strict_q : url_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			url_q    <= b64d_pkg::RESET_URL_ALPHABET;
			strict_q <= b64d_pkg::RESET_STRICT_PAD;
		end else if (wr_en) begin
			if (reg_idx == b64d_pkg::REG_URL_ALPHABET[0])
				url_q <= pwdata[0];
			else
				strict_q <= pwdata[0];
		end
	end

	b64d_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tlast        (s_tlast),
		.url_alphabet   (url_q),
		.strict_pad     (strict_q),
		.load_ok        (load_ok),
		.batch_load     (batch_load),
		.batch          (batch)
	);

	b64d_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.batch_load (batch_load),
		.batch      (batch),
		.load_ok    (load_ok),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

/* rtl/b64d_core.sv */
// Input register, group state and decode of one character per cycle unless a batch waits for the buffer.
// Depends on b64d_pkg; hands a batch of up to three results to b64d_outq.
module b64d_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // text_char
	input  logic              s_tlast,   // message_end
	input  logic              url_alphabet,
	input  logic              strict_pad,
	input  logic              load_ok,
	output logic              batch_load,
	output b64d_pkg::batch_t  batch
);

	typedef enum logic [1:0] {SYM_DATA, SYM_EQ, SYM_BAD} sym_kind_t;

	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        last_s1;

	logic [17:0] store_q;
	logic [1:0]  place_q;
	logic [1:0]  pad_q;
	logic        reject_q;

	sym_kind_t   kind;
	logic [5:0]  sextet;
	logic [7:0]  off_upper, off_lower, off_digit;

	logic [23:0] acc;
	logic [23:0] v;
	logic [17:0] store_d;
	logic [1:0]  place_d;
	logic [1:0]  pad_d;
	logic        reject_d;
	logic        rej;
	logic [2:0]  chars;
	logic [2:0]  dcnt;
	logic        adv;
	b64d_pkg::batch_t nb;

	// Character to sextet
	assign off_upper = char_s1 - b64d_pkg::CHAR_UPPER_A;
	assign off_lower = char_s1 - b64d_pkg::CHAR_LOWER_A;
	assign off_digit = char_s1 - b64d_pkg::CHAR_DIGIT_0;

	always_comb begin
		kind   = SYM_BAD;
		sextet = '0;
		if (char_s1 >= b64d_pkg::CHAR_UPPER_A && char_s1 <= b64d_pkg::CHAR_UPPER_Z) begin
			kind   = SYM_DATA;
			sextet = off_upper[5:0];
		end else if (char_s1 >= b64d_pkg::CHAR_LOWER_A && char_s1 <= b64d_pkg::CHAR_LOWER_Z) begin
			kind   = SYM_DATA;
			sextet = off_lower[5:0] + b64d_pkg::SEXTET_LOWER_BASE;
		end else if (char_s1 >= b64d_pkg::CHAR_DIGIT_0 && char_s1 <= b64d_pkg::CHAR_DIGIT_9) begin
			kind   = SYM_DATA;
			sextet = off_digit[5:0] + b64d_pkg::SEXTET_DIGIT_BASE;
		end else if (char_s1 == (url_alphabet ? b64d_pkg::CHAR_MINUS : b64d_pkg::CHAR_PLUS)) begin
			kind   = SYM_DATA;
			sextet = b64d_pkg::SEXTET_62;
		end else if (char_s1 == (url_alphabet ? b64d_pkg::CHAR_UNDERSCORE
				: b64d_pkg::CHAR_SLASH)) begin
			kind   = SYM_DATA;
			sextet = b64d_pkg::SEXTET_63;
		end else if (char_s1 == b64d_pkg::CHAR_PAD) begin
			kind   = SYM_EQ;
		end
	end

	// Group update and result batch
	always_comb begin
		rej     = reject_q;
		pad_d   = pad_q;
		store_d = store_q;
		acc     = {6'd0, store_q};
		v       = acc;
		chars   = {1'b0, place_q} + 3'd1;
		dcnt    = '0;
		nb      = '0;
		case (kind)
			SYM_DATA: begin
				if (pad_q != 2'd0)
					rej = 1'b1;
				acc     = {store_q, sextet};
				store_d = acc[17:0];
			end
			SYM_EQ: begin
				if (place_q < 2'd2)
					rej = 1'b1;
				else
					pad_d = pad_q + 2'd1;
			end
			default: rej = 1'b1;
		endcase

		place_d  = place_q + 2'd1;
		reject_d = rej;

		if (!last_s1) begin
			if (place_q == 2'd3) begin
				if (pad_d != 2'd0)
					rej = 1'b1;
				if (!rej) begin
					nb.count  = 2'd3;
					nb.res[0] = '{acc[23:16], 1'b1, 1'b0, 1'b0};
					nb.res[1] = '{acc[15:8],  1'b1, 1'b0, 1'b0};
					nb.res[2] = '{acc[7:0],   1'b1, 1'b0, 1'b0};
				end
				store_d  = '0;
				place_d  = '0;
				pad_d    = '0;
				reject_d = rej;
			end
		end else begin
			dcnt = ({1'b0, pad_d} <= chars) ? chars - {1'b0, pad_d} : 3'd0;
			if (dcnt < 3'd2)
				rej = 1'b1;
			if (strict_pad && place_q != 2'd3)
				rej = 1'b1;
			case (dcnt)
				3'd2:    v = {acc[11:0], 12'd0};
				3'd3:    v = {acc[17:0], 6'd0};
				default: v = acc;
			endcase
			// leftover bits must be zero in strict mode
			if (strict_pad && ((dcnt == 3'd2 && v[15:8] != 8'd0)
					|| (dcnt == 3'd3 && v[7:0] != 8'd0)))
				rej = 1'b1;
			if (rej) begin
				nb.count  = 2'd1;
				nb.res[0] = '{8'd0, 1'b0, 1'b1, 1'b1};
			end else begin
				nb.count  = dcnt[1:0] - 2'd1;
				nb.res[0] = '{v[23:16], 1'b1, 1'b0, dcnt == 3'd2};
				nb.res[1] = '{v[15:8],  1'b1, 1'b0, dcnt == 3'd3};
				nb.res[2] = '{v[7:0],   1'b1, 1'b0, dcnt == 3'd4};
			end
			store_d  = '0;
			place_d  = '0;
			pad_d    = '0;
			reject_d = 1'b0;
		end
	end

	assign adv        = valid_s1 && (nb.count == 2'd0 || load_ok);
	assign batch_load = adv && nb.count != 2'd0;
	assign batch      = nb;
	assign s_tready   = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			store_q  <= '0;
			place_q  <= '0;
			pad_q    <= '0;
			reject_q <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (adv) begin
				store_q  <= store_d;
				place_q  <= place_d;
				pad_q    <= pad_d;
				reject_q <= reject_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

endmodule

/* rtl/b64d_outq.sv */
// Result buffer: holds the batch of one item and hands it out one result a time.
// Depends on b64d_pkg; loaded by b64d_core.
module b64d_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              batch_load,
	input  b64d_pkg::batch_t  batch,
	output logic              load_ok,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,   // data_byte
	output logic [1:0]        m_tuser,   // [0] byte_valid, [1] rejected
	output logic              m_tlast    // closing
);

	logic [1:0]        cnt_q;
	b64d_pkg::result_t [b64d_pkg::MAX_RESULTS-1:0] slot_q;
	logic              pop;

	assign pop      = cnt_q != 2'd0 && m_tready;
	assign load_ok  = cnt_q == 2'd0 || (cnt_q == 2'd1 && pop);
	assign m_tvalid = cnt_q != 2'd0;
	assign m_tdata  = slot_q[0].data_byte;
	assign m_tuser  = {slot_q[0].rejected, slot_q[0].byte_valid};
	assign m_tlast  = slot_q[0].closing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (batch_load) begin
			cnt_q <= batch.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (batch_load) begin
			slot_q <= batch.res;
		end else if (pop) begin
			slot_q[0] <= slot_q[1];
			slot_q[1] <= slot_q[2];
		end
	end

endmodule

/* rtl/b64d_checker.sv */
// Port-level checks for the Base64 decoder, bound to the top level.
// Depends on base64_decoder_checked's ports only.
module b64d_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [1:0] m_tuser,
	input logic       m_tlast
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	// reject only on the closing result
	a_rej_close: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast)
		else $error("reject flag away from closing result");

	// a rejected result carries no byte
	a_rej_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> !m_tuser[0] && m_tdata == 8'd0)
		else $error("rejected result carries data");

	// every result without a byte is a rejection
	a_nobyte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tuser[1])
		else $error("empty result without reject");

endmodule

bind base64_decoder_checked b64d_checker u_b64d_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

/* tb/tb_top.sv */
// Self-checking testbench for base64_decoder_checked: character stream in, decoded items out.
// Predicts every result from its own decoder model and drives configuration over APB.
// Depends on b64d_pkg and the RTL top level only.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int RANDOM_ITEMS   = 60;   // per configuration phase, four phases

	typedef enum logic [1:0] {SYM_DATA, SYM_PAD, SYM_BAD} sym_kind_t;
	typedef enum logic [1:0] {RX_STEADY, RX_RANDOM, RX_SPARSE} rx_mode_t;

	logic                          clk      = 1'b0;
	logic                          arst_n   = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [7:0]                    s_tdata  = '0;
	logic                          s_tlast  = 1'b0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [7:0]                    m_tdata;
	logic [1:0]                    m_tuser;
	logic                          m_tlast;
	logic                          psel     = 1'b0;
	logic                          penable  = 1'b0;
	logic                          pwrite   = 1'b0;
	logic [b64d_pkg::ADDR_W-1:0]   paddr    = '0;
	logic [31:0]                   pwdata   = '0;
	logic [31:0]                   prdata;
	logic                          pready;

	base64_decoder_checked i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #4 clk = ~clk;

	// Decoder model state and its copy of the registers
	logic [17:0] held_sextets = '0;
	logic [1:0]  char_pos     = '0;
	logic [1:0]  pad_count    = '0;
	logic        msg_bad      = 1'b0;
	logic        cfg_url      = b64d_pkg::RESET_URL_ALPHABET;
	logic        cfg_strict   = b64d_pkg::RESET_STRICT_PAD;

	b64d_pkg::result_t decoded_results[$];
	b64d_pkg::result_t want;
	logic [7:0]  text_q[$];

	int          error_count = 0;
	int          items_sent  = 0;
	int          idle_cycles = 0;
	int          burst_left  = 0;
	rx_mode_t    rx_mode     = RX_STEADY;
	int          rx_count    = 0;

	function automatic sym_kind_t classify(input logic [7:0] c, output logic [5:0] sx);
		sx = '0;
		if (c >= b64d_pkg::CHAR_UPPER_A && c <= b64d_pkg::CHAR_UPPER_Z) begin
			sx = 6'(c - b64d_pkg::CHAR_UPPER_A);
			return SYM_DATA;
		end
		if (c >= b64d_pkg::CHAR_LOWER_A && c <= b64d_pkg::CHAR_LOWER_Z) begin
			sx = 6'(c - b64d_pkg::CHAR_LOWER_A) + b64d_pkg::SEXTET_LOWER_BASE;
			return SYM_DATA;
		end
		if (c >= b64d_pkg::CHAR_DIGIT_0 && c <= b64d_pkg::CHAR_DIGIT_9) begin
			sx = 6'(c - b64d_pkg::CHAR_DIGIT_0) + b64d_pkg::SEXTET_DIGIT_BASE;
			return SYM_DATA;
		end
		if (c == (cfg_url ? b64d_pkg::CHAR_MINUS : b64d_pkg::CHAR_PLUS)) begin
			sx = b64d_pkg::SEXTET_62;
			return SYM_DATA;
		end
		if (c == (cfg_url ? b64d_pkg::CHAR_UNDERSCORE : b64d_pkg::CHAR_SLASH)) begin
			sx = b64d_pkg::SEXTET_63;
			return SYM_DATA;
		end
		if (c == b64d_pkg::CHAR_PAD)
			return SYM_PAD;
		return SYM_BAD;
	endfunction

	function automatic logic [7:0] sextet_char(input logic [5:0] sx, input logic url);
		if (sx < b64d_pkg::SEXTET_LOWER_BASE)
			return b64d_pkg::CHAR_UPPER_A + 8'(sx);
		if (sx < b64d_pkg::SEXTET_DIGIT_BASE)
			return b64d_pkg::CHAR_LOWER_A + 8'(sx - b64d_pkg::SEXTET_LOWER_BASE);
		if (sx < b64d_pkg::SEXTET_62)
			return b64d_pkg::CHAR_DIGIT_0 + 8'(sx - b64d_pkg::SEXTET_DIGIT_BASE);
		if (sx == b64d_pkg::SEXTET_62)
			return url ? b64d_pkg::CHAR_MINUS : b64d_pkg::CHAR_PLUS;
		return url ? b64d_pkg::CHAR_UNDERSCORE : b64d_pkg::CHAR_SLASH;
	endfunction

	task automatic push_result(input logic [7:0] b, input logic valid, input logic rej,
			input logic close);
		b64d_pkg::result_t r;
		r.data_byte  = b;
		r.byte_valid = valid;
		r.rejected   = rej;
		r.closing    = close;
		decoded_results.push_back(r);
	endtask

	task automatic clear_group();
		held_sextets = '0;
		char_pos     = '0;
		pad_count    = '0;
	endtask

	task automatic decode_char(input logic [7:0] c, input logic last);
		logic [5:0]  sx;
		sym_kind_t   kind;
		logic [23:0] acc;
		logic [23:0] v;
		logic [2:0]  chars;
		logic [2:0]  d;
		int          k;
		kind = classify(c, sx);
		acc  = {6'b0, held_sextets};
		case (kind)
			SYM_DATA: begin
				if (pad_count != 0)
					msg_bad = 1'b1;
				acc          = {held_sextets, sx};
				held_sextets = acc[17:0];
			end
			SYM_PAD: begin
				if (char_pos < 2)
					msg_bad = 1'b1;
				else
					pad_count = pad_count + 2'd1;
			end
			default: msg_bad = 1'b1;
		endcase

		if (!last) begin
			if (char_pos == 2'd3) begin
				// '=' is only allowed in the closing group
				if (pad_count != 0)
					msg_bad = 1'b1;
				if (!msg_bad) begin
					push_result(acc[23:16], 1'b1, 1'b0, 1'b0);
					push_result(acc[15:8], 1'b1, 1'b0, 1'b0);
					push_result(acc[7:0], 1'b1, 1'b0, 1'b0);
				end
				clear_group();
			end else begin
				char_pos = char_pos + 2'd1;
			end
			return;
		end

		chars = {1'b0, char_pos} + 3'd1;
		d     = ({1'b0, pad_count} <= chars) ? chars - {1'b0, pad_count} : 3'd0;
		if (d < 2)
			msg_bad = 1'b1;
		if (cfg_strict && char_pos != 2'd3)
			msg_bad = 1'b1;
		if (!msg_bad) begin
			v = acc << (6 * (4 - d));
			// leftover bits below the last whole byte must be zero in strict mode
			if (cfg_strict && ((d == 3'd2 && v[15:8] != 0) || (d == 3'd3 && v[7:0] != 0)))
				msg_bad = 1'b1;
			if (!msg_bad)
				for (k = 0; k < d - 1; k++)
					push_result(v[23 - 8*k -: 8], 1'b1, 1'b0, k == d - 2);
		end
		if (msg_bad)
			push_result(8'h00, 1'b0, 1'b1, 1'b1);
		clear_group();
		msg_bad = 1'b0;
	endtask

	// Both handshakes sampled at the rising edge, before any update of this step lands
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				decode_char(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				if (decoded_results.size() == 0) begin
					$error("unexpected result: data_byte %02h byte_valid %0b rejected %0b closing %0b",
						m_tdata, m_tuser[0], m_tuser[1], m_tlast);
					error_count++;
				end else begin
					want = decoded_results.pop_front();
					if (m_tdata !== want.data_byte) begin
						$error("data_byte: expected %02h, got %02h", want.data_byte, m_tdata);
						error_count++;
					end
					if (m_tuser[0] !== want.byte_valid) begin
						$error("byte_valid: expected %0b, got %0b", want.byte_valid, m_tuser[0]);
						error_count++;
					end
					if (m_tuser[1] !== want.rejected) begin
						$error("rejected: expected %0b, got %0b", want.rejected, m_tuser[1]);
						error_count++;
					end
					if (m_tlast !== want.closing) begin
						$error("closing: expected %0b, got %0b", want.closing, m_tlast);
						error_count++;
					end
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// Receiver: switches between always ready, random stalls and sparse acceptance
	always @(posedge clk) begin
		if (rx_count == 0) begin
			rx_mode  <= rx_mode_t'($urandom_range(0, 2));
			rx_count <= $urandom_range(20, 80);
		end else begin
			rx_count <= rx_count - 1;
		end
		case (rx_mode)
			RX_STEADY: m_tready <= 1'b1;
			RX_RANDOM: m_tready <= ($urandom_range(0, 2) != 0);
			default:   m_tready <= (rx_count[1:0] == 2'd0);
		endcase
	end

	initial begin
		while (idle_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic send_char(input logic [7:0] c, input logic last);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 10);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= last;
		do
			@(posedge clk);
		while (s_tready !== 1'b1);
		items_sent++;
	endtask

	task automatic send_text_q();
		int i;
		for (i = 0; i < text_q.size(); i++)
			send_char(text_q[i], i == text_q.size() - 1);
	endtask

	task automatic send_text(input string s);
		int i;
		text_q.delete();
		for (i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
		send_text_q();
	endtask

	// Stops the stream and lets the block drain before any register access
	task automatic settle();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (decoded_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input int unsigned idx, input logic value);
		logic [31:0] wdata;
		wdata    = $urandom();
		wdata[0] = value;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= (b64d_pkg::ADDR_W)'(4 * idx);
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// write lands here; the read-back setup follows straight on
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[0] !== value) begin
			$error("register %0d read-back: expected %0b, got %0b", idx, value, prdata[0]);
			error_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		if (idx == b64d_pkg::REG_URL_ALPHABET)
			cfg_url = value;
		else
			cfg_strict = value;
	endtask

	task automatic set_config(input logic url, input logic strict);
		reg_write(b64d_pkg::REG_URL_ALPHABET, url);
		reg_write(b64d_pkg::REG_STRICT_PAD, strict);
	endtask

	// Encodes nbytes random bytes; dirty puts nonzero bits below the last whole byte
	task automatic encode_random(input int nbytes, input logic pad, input logic dirty);
		int          i;
		int          k;
		int          rem;
		int          nchars;
		logic [23:0] word;
		text_q.delete();
		for (i = 0; i < nbytes; i += 3) begin
			rem  = nbytes - i;
			word = 24'($urandom());
			if (rem == 1) begin
				word[15:0] = '0;
				if (dirty)
					word[15:12] = 4'($urandom_range(1, 15));
			end else if (rem == 2) begin
				word[7:0] = '0;
				if (dirty)
					word[7:6] = 2'($urandom_range(1, 3));
			end
			nchars = (rem >= 3) ? 4 : rem + 1;
			for (k = 0; k < nchars; k++)
				text_q.push_back(sextet_char(word[23 - 6*k -: 6], cfg_url));
			if (pad)
				for (k = nchars; k < 4; k++)
					text_q.push_back(b64d_pkg::CHAR_PAD);
		end
	endtask

	task automatic make_random_message();
		int kind;
		int nbytes;
		int pos;
		kind   = $urandom_range(0, 9);
		nbytes = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
		if (kind == 9) begin
			text_q.delete();
			repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
			return;
		end
		// padding follows the mode, except for the deliberate mismatch
		encode_random(nbytes, (kind == 8) ? !cfg_strict : (cfg_strict || $urandom_range(0, 1)),
			$urandom_range(0, 4) == 0);
		if (kind < 6 || kind == 8)
			return;
		pos = $urandom_range(0, text_q.size() - 1);
		case ($urandom_range(0, 3))
			0: text_q[pos] = 8'($urandom_range(0, 255));
			1: text_q[pos] = b64d_pkg::CHAR_PAD;
			2: text_q[pos] = cfg_url
				? ($urandom_range(0, 1) ? b64d_pkg::CHAR_PLUS : b64d_pkg::CHAR_SLASH)
				: ($urandom_range(0, 1) ? b64d_pkg::CHAR_MINUS : b64d_pkg::CHAR_UNDERSCORE);
			default: text_q = text_q[0:pos];
		endcase
	endtask

	task automatic test_standard_strict();
		set_config(1'b0, 1'b1);
		send_text("+/9z");
		send_text("QQ==");
		send_text("Zm8=");
		send_text("=AAA");        // '=' opening a group
		send_text("QQ=A");        // data after '='
		send_text("QQ==QQ==");    // padding in a group that is not the last
		send_text("QR==");        // leftover bits set
		text_q.delete();          // bytes outside the alphabet, then the URL-safe symbol
		text_q.push_back(8'h00);
		text_q.push_back(8'hFF);
		text_q.push_back(b64d_pkg::CHAR_MINUS);
		text_q.push_back(b64d_pkg::CHAR_UPPER_A);
		send_text_q();
		send_text("Q");           // one data character only
		settle();
	endtask

	task automatic test_url_relaxed();
		set_config(1'b1, 1'b0);
		send_text("-_-_AR");      // short group with leftover bits, allowed here
		send_text("ZmA");
		send_text("+/");          // standard symbols are invalid in this alphabet
		send_text("Q=");          // padding leaves a single data character
		settle();
	endtask

	task automatic test_random_messages(input logic url, input logic strict);
		int start;
		set_config(url, strict);
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			make_random_message();
			send_text_q();
		end
		settle();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_standard_strict();
		test_url_relaxed();
		test_random_messages(1'b0, 1'b1);
		test_random_messages(1'b1, 1'b0);
		test_random_messages(1'b1, 1'b1);
		test_random_messages(1'b0, 1'b0);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
